// ----- hw/rtl/tmib_pkg.sv -----
// ----------------------------------------------------------------------------
// tmib_pkg
// shared types, widths and codes of the triangle mesh index builder
// ----------------------------------------------------------------------------
package tmib_pkg;

    localparam int COORD_W          = 32;
    localparam int EXT_W            = 31;
    localparam int FRAC_W           = 16;
    localparam int UV_W             = 17;
    localparam int IDX_W            = 10;
    localparam int STATUS_W         = 2;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_W            = 32;
    localparam int IN_TDATA_W       = 192;
    localparam int OUT_TDATA_W      = 112;
    localparam int FIFO_DEPTH       = 4;
    localparam int MAX_VERTICES_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 4'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } corner_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [EXT_W-1:0]          extent_x;
        logic [EXT_W-1:0]          extent_y;
    } cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL_P,
        F_MUL_Q,
        F_CMP,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SEARCH,
        B_FINISH
    } back_state_t;

endpackage

// ----- hw/rtl/triangle_mesh_index_builder_top.sv -----
// ----------------------------------------------------------------------------
// triangle_mesh_index_builder_top
// welds triangle corners into a shared vertex table and emits indexed results
// ----------------------------------------------------------------------------
// path: front winding fix, corner queue, then back end search, uv division and result register
// three beats per triangle, one per corner; the table scan reads one entry per cycle
// the back end takes the next corner only once the last result is loaded, and each
// corner waits for both the table scan and the uv division, so a full table scans longest
// reset: vertex count and handshakes clear at once, config takes its defaults,
// table contents need no clearing pass
// ----------------------------------------------------------------------------
module triangle_mesh_index_builder_top
    import tmib_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // vertex_index, is_new, pos_x, pos_y, tex_u, tex_v, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]    m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    cfg_t    cfg_reg;
    corner_t push_data, pop_data;
    logic    push_valid, push_ready, pop_valid, pop_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.extent_x <= EXT_W'(1 << FRAC_W);
            cfg_reg.extent_y <= EXT_W'(1 << FRAC_W);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: cfg_reg.origin_x <= cfg_data;
                CFG_ORIGIN_Y: cfg_reg.origin_y <= cfg_data;
                CFG_EXTENT_X: cfg_reg.extent_x <= cfg_data[EXT_W-1:0];
                CFG_EXTENT_Y: cfg_reg.extent_y <= cfg_data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    tmib_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    tmib_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    tmib_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- hw/rtl/tmib_front.sv -----
// ----------------------------------------------------------------------------
// tmib_front
// takes a triangle, fixes winding with a shared multiplier, queues its corners
// ----------------------------------------------------------------------------
module tmib_front
    import tmib_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output corner_t               push_data,
    output logic                  push_valid,
    input  logic                  push_ready
);

    front_state_t state_reg, state_next;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [2*COORD_W+1:0] p_reg, q_reg, prod;
    logic signed [COORD_W:0] d_bx, d_by, d_cx, d_cy, mul_a, mul_b;
    logic swap_reg;
    logic [1:0] sel_reg;

    assign d_bx = {bx_reg[COORD_W-1], bx_reg} - {ax_reg[COORD_W-1], ax_reg};
    assign d_by = {by_reg[COORD_W-1], by_reg} - {ay_reg[COORD_W-1], ay_reg};
    assign d_cx = {cx_reg[COORD_W-1], cx_reg} - {ax_reg[COORD_W-1], ax_reg};
    assign d_cy = {cy_reg[COORD_W-1], cy_reg} - {ay_reg[COORD_W-1], ay_reg};
    assign mul_a = (state_reg == F_MUL_P) ? d_bx : d_cx;
    assign mul_b = (state_reg == F_MUL_P) ? d_cy : d_by;
    assign prod  = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = F_MUL_P;
                end
            end
            F_MUL_P: state_next = F_MUL_Q;
            F_MUL_Q: state_next = F_CMP;
            F_CMP:   state_next = F_PUSH;
            F_PUSH:
            begin
                if (push_ready && sel_reg == 2'd2)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = (state_reg == F_IDLE);
        push_valid = (state_reg == F_PUSH);
        push_data.last = (sel_reg == 2'd2);
        case (sel_reg)
            2'd0:
            begin
                push_data.x = ax_reg;
                push_data.y = ay_reg;
            end
            2'd1:
            begin
                push_data.x = swap_reg ? cx_reg : bx_reg;
                push_data.y = swap_reg ? cy_reg : by_reg;
            end
            default:
            begin
                push_data.x = swap_reg ? bx_reg : cx_reg;
                push_data.y = swap_reg ? by_reg : cy_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_CMP)
            begin
                sel_reg <= 2'd0;
            end
            else if (state_reg == F_PUSH && push_ready)
            begin
                sel_reg <= sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && s_tvalid)
        begin
            ax_reg <= s_tdata[31:0];
            ay_reg <= s_tdata[63:32];
            bx_reg <= s_tdata[95:64];
            by_reg <= s_tdata[127:96];
            cx_reg <= s_tdata[159:128];
            cy_reg <= s_tdata[191:160];
        end
        if (state_reg == F_MUL_P)
        begin
            p_reg <= prod;
        end
        if (state_reg == F_MUL_Q)
        begin
            q_reg <= prod;
        end
        if (state_reg == F_CMP)
        begin
            swap_reg <= (p_reg > q_reg);
        end
    end

endmodule

// ----- hw/rtl/tmib_fifo.sv -----
// ----------------------------------------------------------------------------
// tmib_fifo
// short corner queue between front and back
// ----------------------------------------------------------------------------
module tmib_fifo
    import tmib_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  corner_t push_data,
    input  logic    push_valid,
    output logic    push_ready,
    output corner_t pop_data,
    output logic    pop_valid,
    input  logic    pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    corner_t         slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   fill_reg;
    logic            do_push, do_pop;

    assign push_ready = (fill_reg != CW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/tmib_back.sv -----
// ----------------------------------------------------------------------------
// tmib_back
// vertex table search and append, uv division, result register
// ----------------------------------------------------------------------------
module tmib_back
    import tmib_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  corner_t                pop_data,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // vertex_index, is_new, pos_x, pos_y, tex_u, tex_v, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]    m_tuser,
    output logic                   m_tlast
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DCW = $clog2(FRAC_W + 1);

    back_state_t state_reg, state_next;
    corner_t cur_reg;
    logic degen_reg;
    logic [CW-1:0] count_reg, issue_reg, chk_reg;
    logic pend_reg, found_reg;
    logic [AW-1:0] idx_reg;
    logic [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic [COORD_W-1:0] mem_y [MAX_VERTICES];
    logic [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic [EXT_W-1:0] rem_u_reg, rem_v_reg;
    logic [FRAC_W-1:0] q_u_reg, q_v_reg;
    logic zero_u_reg, zero_v_reg, sat_u_reg, sat_v_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic out_valid_reg, out_last_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic signed [COORD_W:0] du, dv;
    logic [EXT_W:0] tu, tv;
    logic hit_now, read_en, search_done, div_done, load;
    logic miss, full, is_new;
    logic [AW-1:0] idx_sel;
    logic [STATUS_W-1:0] status;
    logic [UV_W-1:0] tex_u, tex_v;
    logic [IDX_W-1:0] vertex_index;

    assign du = {pop_data.x[COORD_W-1], pop_data.x}
              - {cfg.origin_x[COORD_W-1], cfg.origin_x};
    assign dv = {pop_data.y[COORD_W-1], pop_data.y}
              - {cfg.origin_y[COORD_W-1], cfg.origin_y};
    assign tu = {rem_u_reg, 1'b0};
    assign tv = {rem_v_reg, 1'b0};

    assign hit_now = pend_reg && rd_x_reg == cur_reg.x && rd_y_reg == cur_reg.y;
    assign read_en = (state_reg == B_SEARCH) && !found_reg && !hit_now
                   && !degen_reg && (issue_reg < count_reg);
    assign search_done = degen_reg || found_reg || (!pend_reg && issue_reg >= count_reg);
    assign div_done = (div_cnt_reg == DCW'(FRAC_W));

    assign miss   = !found_reg;
    assign full   = (count_reg == CW'(MAX_VERTICES));
    assign is_new = !degen_reg && miss && !full;
    assign status = degen_reg ? STATUS_DEGEN : ((miss && full) ? STATUS_FULL : STATUS_OK);
    assign idx_sel = (degen_reg || (miss && full)) ? '0
                   : (found_reg ? idx_reg : count_reg[AW-1:0]);
    assign vertex_index = IDX_W'(idx_sel);
    assign tex_u = (degen_reg || zero_u_reg) ? '0
                 : (sat_u_reg ? UV_W'(1 << FRAC_W) : {1'b0, q_u_reg});
    assign tex_v = (degen_reg || zero_v_reg) ? '0
                 : (sat_v_reg ? UV_W'(1 << FRAC_W) : {1'b0, q_v_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = B_SEARCH;
                end
            end
            B_SEARCH:
            begin
                if (search_done && div_done)
                begin
                    state_next = B_FINISH;
                end
            end
            B_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready = (state_reg == B_IDLE);
        load      = (state_reg == B_FINISH) && (!out_valid_reg || m_tready);
        m_tvalid  = out_valid_reg;
        m_tdata   = out_data_reg;
        m_tuser   = out_status_reg;
        m_tlast   = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && pop_valid)
            begin
                issue_reg   <= '0;
                pend_reg    <= 1'b0;
                found_reg   <= 1'b0;
                div_cnt_reg <= '0;
            end
            if (state_reg == B_SEARCH)
            begin
                if (hit_now)
                begin
                    found_reg <= 1'b1;
                end
                pend_reg <= read_en;
                if (read_en)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                if (!div_done)
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (is_new)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid)
        begin
            cur_reg    <= pop_data;
            degen_reg  <= (cfg.extent_x == '0) || (cfg.extent_y == '0);
            zero_u_reg <= du[COORD_W] || (du == '0);
            zero_v_reg <= dv[COORD_W] || (dv == '0);
            sat_u_reg  <= !du[COORD_W] && (du[COORD_W-1:0] >= {1'b0, cfg.extent_x});
            sat_v_reg  <= !dv[COORD_W] && (dv[COORD_W-1:0] >= {1'b0, cfg.extent_y});
            rem_u_reg  <= du[EXT_W-1:0];
            rem_v_reg  <= dv[EXT_W-1:0];
            q_u_reg    <= '0;
            q_v_reg    <= '0;
        end
        if (state_reg == B_SEARCH && !div_done)
        begin
            if (tu >= {1'b0, cfg.extent_x})
            begin
                rem_u_reg <= EXT_W'(tu - {1'b0, cfg.extent_x});
                q_u_reg   <= {q_u_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_u_reg <= tu[EXT_W-1:0];
                q_u_reg   <= {q_u_reg[FRAC_W-2:0], 1'b0};
            end
            if (tv >= {1'b0, cfg.extent_y})
            begin
                rem_v_reg <= EXT_W'(tv - {1'b0, cfg.extent_y});
                q_v_reg   <= {q_v_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_v_reg <= tv[EXT_W-1:0];
                q_v_reg   <= {q_v_reg[FRAC_W-2:0], 1'b0};
            end
        end
        if (state_reg == B_SEARCH && hit_now)
        begin
            idx_reg <= chk_reg[AW-1:0];
        end
        if (read_en)
        begin
            rd_x_reg <= mem_x[issue_reg[AW-1:0]];
            rd_y_reg <= mem_y[issue_reg[AW-1:0]];
            chk_reg  <= issue_reg;
        end
        if (load && is_new)
        begin
            mem_x[count_reg[AW-1:0]] <= cur_reg.x;
            mem_y[count_reg[AW-1:0]] <= cur_reg.y;
        end
        if (load)
        begin
            out_data_reg <= {3'b000, tex_v, tex_u, cur_reg.y, cur_reg.x,
                             is_new, vertex_index};
            out_status_reg <= status;
            out_last_reg   <= cur_reg.last;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count beyond table size");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_new) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance vertex count");

    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SEARCH && found_reg) |-> (CW'(idx_reg) < count_reg))
        else $error("hit index outside filled table");

endmodule

// ----- tb/triangle_mesh_index_builder_top_tb.sv -----
// ----------------------------------------------------------------------------
// triangle_mesh_index_builder_top_tb
// streams triangles through the mesh index builder and checks every vertex beat
// against a behavioral predictor of welding, winding fix and uv normalization,
// across several bounding box settings and degenerate boxes
// ----------------------------------------------------------------------------
module triangle_mesh_index_builder_top_tb
    import tmib_pkg::*;
();

    localparam int  TABLE_DEPTH = MAX_VERTICES_DEF;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  HOLD_CYCLES = 400;
    localparam int  SETTLE      = 40;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [16:0] UV_ONE = 17'h10000;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic                fresh;
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        logic [UV_W-1:0]     u;
        logic [UV_W-1:0]     v;
        logic [STATUS_W-1:0] st;
        logic                lst;
    } vertex_beat_t;

    typedef struct packed {
        logic [IN_TDATA_W-1:0] tri_data;
        logic                  degen_box;
        logic                  typed;
        logic [IDX_W-1:0]      idx;
        logic                  fresh;
        logic [STATUS_W-1:0]   st;
        logic [UV_W-1:0]       u;
        logic [UV_W-1:0]       v;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // vertex_index, is_new, pos_x, pos_y, tex_u, tex_v, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;
    // status
    logic [STATUS_W-1:0]    m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // predictor state
    logic [COORD_W-1:0]        weld_x [TABLE_DEPTH];
    logic [COORD_W-1:0]        weld_y [TABLE_DEPTH];
    int                        weld_count;
    logic signed [COORD_W-1:0] box_org_x;
    logic signed [COORD_W-1:0] box_org_y;
    logic [EXT_W-1:0]          box_ext_x;
    logic [EXT_W-1:0]          box_ext_y;

    vertex_beat_t  pending_beats[$];
    logic [63:0]   seen_corners[$];
    stim_row_t     dir_rows[$];
    int            errors = 0;
    int            cycles = 0;
    bit            tx_fast = 1'b0;
    bit            rx_fast = 1'b0;
    int            hold_token = 0;
    int            hold_seen = 0;
    int            hold_left = 0;
    int            rx_stall = 0;

    triangle_mesh_index_builder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("triangle_mesh_index_builder_top_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [UV_W-1:0] norm_coord(logic signed [31:0] c,
                                                   logic signed [31:0] o,
                                                   logic [EXT_W-1:0] e);
        longint d;
        longint ext;
        d   = longint'(c) - longint'(o);
        ext = longint'({33'd0, e});
        if (d <= 0 || ext == 0)
            return '0;
        if (d >= ext)
            return UV_ONE;
        return UV_W'((d << 16) / ext);
    endfunction

    function automatic vertex_beat_t weld_corner(logic [31:0] x, logic [31:0] y,
                                                 bit degen, bit lst);
        vertex_beat_t b;
        bit hit;
        hit   = 1'b0;
        b     = '0;
        b.px  = x;
        b.py  = y;
        b.lst = lst;
        if (degen)
        begin
            b.st = STATUS_DEGEN;
            return b;
        end
        b.st = STATUS_OK;
        b.u  = norm_coord(x, box_org_x, box_ext_x);
        b.v  = norm_coord(y, box_org_y, box_ext_y);
        for (int i = 0; i < weld_count; i++)
        begin
            if (!hit && weld_x[i] == x && weld_y[i] == y)
            begin
                hit   = 1'b1;
                b.idx = IDX_W'(i);
            end
        end
        if (!hit)
        begin
            if (weld_count >= TABLE_DEPTH)
                b.st = STATUS_FULL;
            else
            begin
                b.idx              = IDX_W'(weld_count);
                weld_x[weld_count] = x;
                weld_y[weld_count] = y;
                weld_count++;
                b.fresh = 1'b1;
            end
        end
        return b;
    endfunction

    task automatic predict_triangle(input logic [IN_TDATA_W-1:0] t);
        logic signed [31:0] ax, ay, bx, by, cx, cy, sw;
        logic signed [67:0] d1, d2, d3, d4, p, q;
        bit degen;
        {cy, cx, by, bx, ay, ax} = t;
        degen = (box_ext_x == 0) || (box_ext_y == 0);
        d1 = 68'(longint'(bx) - longint'(ax));
        d2 = 68'(longint'(cy) - longint'(ay));
        d3 = 68'(longint'(cx) - longint'(ax));
        d4 = 68'(longint'(by) - longint'(ay));
        p  = d1 * d2;
        q  = d3 * d4;
        if (p > q)
        begin
            sw = bx; bx = cx; cx = sw;
            sw = by; by = cy; cy = sw;
        end
        pending_beats.insert(pending_beats.size(), weld_corner(ax, ay, degen, 1'b0));
        pending_beats.insert(pending_beats.size(), weld_corner(bx, by, degen, 1'b0));
        pending_beats.insert(pending_beats.size(), weld_corner(cx, cy, degen, 1'b1));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORIGIN_X: box_org_x = val;
            CFG_ORIGIN_Y: box_org_y = val;
            CFG_EXTENT_X: box_ext_x = val[EXT_W-1:0];
            CFG_EXTENT_Y: box_ext_y = val[EXT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] ex, input logic [31:0] ey);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_EXTENT_X, ex);
        write_reg(CFG_EXTENT_Y, ey);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_beats.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_triangle(input logic [IN_TDATA_W-1:0] t);
        int gap;
        s_tdata  <= t;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_triangle(t);
        for (int k = 0; k < 3; k++)
            if (seen_corners.size() < 200)
                seen_corners.insert(seen_corners.size(), t[k*64 +: 64]);
        gap = tx_fast ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] edge_coord();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return Q_MIN;
            2: return Q_MAX;
            3: return Q_ONE;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    function automatic logic [63:0] pick_corner(bit fresh_only);
        int r;
        r = $urandom_range(0, 99);
        if (fresh_only)
            return {$urandom(), $urandom()};
        if (r < 40 && seen_corners.size() > 0)
            return seen_corners[$urandom_range(0, seen_corners.size() - 1)];
        if (r < 55)
            return {edge_coord(), edge_coord()};
        if (r < 80)
            return {box_org_y + 32'($urandom_range(0, 32'h0004_0000)) - 32'h1000,
                    box_org_x + 32'($urandom_range(0, 32'h0004_0000)) - 32'h1000};
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_triangles(input int n, input bit fresh_only);
        for (int i = 0; i < n; i++)
        begin
            if (!fresh_only)
            begin
                tx_fast = ($urandom_range(0, 3) == 0);
                rx_fast = ($urandom_range(0, 3) == 0);
            end
            send_triangle({pick_corner(fresh_only), pick_corner(fresh_only),
                           pick_corner(fresh_only)});
        end
    endtask

    function automatic stim_row_t make_row(logic [31:0] ax, logic [31:0] ay,
                                           logic [31:0] bx, logic [31:0] by,
                                           logic [31:0] cx, logic [31:0] cy,
                                           bit degen);
        stim_row_t r;
        r           = '0;
        r.tri_data  = {cy, cx, by, bx, ay, ax};
        r.degen_box = degen;
        return r;
    endfunction

    function automatic stim_row_t typed_row(logic [31:0] x, logic [31:0] y, bit degen,
                                            logic [IDX_W-1:0] idx, bit fresh,
                                            logic [STATUS_W-1:0] st,
                                            logic [UV_W-1:0] u, logic [UV_W-1:0] v);
        stim_row_t r;
        r       = make_row(x, y, x, y, x, y, degen);
        r.typed = 1'b1;
        r.idx   = idx;
        r.fresh = fresh;
        r.st    = st;
        r.u     = u;
        r.v     = v;
        return r;
    endfunction

    // output side: random stalls, long hold-off on request, beat checking
    always @(posedge clk)
    begin
        vertex_beat_t exp_b;
        logic [IDX_W-1:0] got_idx;
        logic got_new;
        logic [31:0] got_x, got_y;
        logic [UV_W-1:0] got_u, got_v;
        if (m_tvalid && m_tready)
        begin
            {got_v, got_u, got_y, got_x, got_new, got_idx} = m_tdata[108:0];
            if (pending_beats.size() == 0)
            begin
                $error("vertex beat with nothing expected");
                errors++;
            end
            else
            begin
                exp_b = pending_beats.pop_front();
                if (got_idx !== exp_b.idx)
                begin
                    $error("vertex_index exp %0d got %0d", exp_b.idx, got_idx);
                    errors++;
                end
                if (got_new !== exp_b.fresh)
                begin
                    $error("is_new exp %0d got %0d", exp_b.fresh, got_new);
                    errors++;
                end
                if (got_x !== exp_b.px)
                begin
                    $error("pos_x exp %h got %h", exp_b.px, got_x);
                    errors++;
                end
                if (got_y !== exp_b.py)
                begin
                    $error("pos_y exp %h got %h", exp_b.py, got_y);
                    errors++;
                end
                if (got_u !== exp_b.u)
                begin
                    $error("tex_u exp %h got %h", exp_b.u, got_u);
                    errors++;
                end
                if (got_v !== exp_b.v)
                begin
                    $error("tex_v exp %h got %h", exp_b.v, got_v);
                    errors++;
                end
                if (m_tuser !== exp_b.st)
                begin
                    $error("status exp %0d got %0d", exp_b.st, m_tuser);
                    errors++;
                end
                if (m_tlast !== exp_b.lst)
                begin
                    $error("last exp %0d got %0d", exp_b.lst, m_tlast);
                    errors++;
                end
            end
            rx_stall = rx_fast ? 0 : $urandom_range(0, 9);
        end
        if (hold_seen != hold_token)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        stim_row_t row;
        bit in_degen;
        in_degen   = 1'b0;
        weld_count = 0;
        box_org_x  = '0;
        box_org_y  = '0;
        box_ext_x  = EXT_W'(32'h0001_0000);
        box_ext_y  = EXT_W'(32'h0001_0000);

        dir_rows.insert(dir_rows.size(), typed_row('0, '0, 0, 0, 1, STATUS_OK, '0, '0));
        dir_rows.insert(dir_rows.size(),
                        typed_row(Q_ONE, Q_ONE, 0, 1, 1, STATUS_OK, UV_ONE, UV_ONE));
        dir_rows.insert(dir_rows.size(),
                        typed_row(Q_MIN, Q_MIN, 0, 2, 1, STATUS_OK, '0, '0));
        dir_rows.insert(dir_rows.size(),
                        typed_row(Q_MAX, Q_MAX, 0, 3, 1, STATUS_OK, UV_ONE, UV_ONE));
        dir_rows.insert(dir_rows.size(),
                        typed_row(32'h8000, 32'h4000, 0, 4, 1, STATUS_OK,
                                  17'h08000, 17'h04000));
        dir_rows.insert(dir_rows.size(), typed_row('0, '0, 0, 0, 0, STATUS_OK, '0, '0));
        // counter-clockwise gets b and c swapped, clockwise stays
        dir_rows.insert(dir_rows.size(), make_row('0, '0, Q_ONE, '0, '0, Q_ONE, 0));
        dir_rows.insert(dir_rows.size(), make_row('0, '0, '0, Q_ONE, Q_ONE, '0, 0));
        dir_rows.insert(dir_rows.size(),
                        make_row(Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 0));
        dir_rows.insert(dir_rows.size(),
                        make_row(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 0));
        dir_rows.insert(dir_rows.size(),
                        make_row(Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 0));
        dir_rows.insert(dir_rows.size(),
                        make_row(32'hFFFF_FFFF, '0, 32'h2_0000, 32'h1, '0, 32'hC000, 0));
        // collinear corners give a zero cross product
        dir_rows.insert(dir_rows.size(),
                        make_row('0, '0, Q_ONE, Q_ONE, 32'h2_0000, 32'h2_0000, 0));
        dir_rows.insert(dir_rows.size(),
                        make_row(32'h4000, 32'hC000, Q_ONE, 32'h4000, 32'h1, 32'h1, 0));
        dir_rows.insert(dir_rows.size(),
                        typed_row(Q_ONE, '0, 1, 0, 0, STATUS_DEGEN, '0, '0));
        dir_rows.insert(dir_rows.size(),
                        typed_row(Q_MAX, Q_MIN, 1, 0, 0, STATUS_DEGEN, '0, '0));
        dir_rows.insert(dir_rows.size(),
                        make_row(Q_MIN, '0, Q_MAX, Q_ONE, 32'h5555, 32'hAAAA, 1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.degen_box && !in_degen)
            begin
                drain();
                write_reg(CFG_EXTENT_X, '0);
                in_degen = 1'b1;
            end
            send_triangle(row.tri_data);
            if (row.typed)
            begin
                pending_beats[pending_beats.size() - 3].idx   = row.idx;
                pending_beats[pending_beats.size() - 3].fresh = row.fresh;
                pending_beats[pending_beats.size() - 3].st    = row.st;
                pending_beats[pending_beats.size() - 3].u     = row.u;
                pending_beats[pending_beats.size() - 3].v     = row.v;
            end
        end
        drain();

        // ordinary box, with one long output hold-off while input keeps coming
        set_box(32'hFFFF_0000, 32'hFFFE_0000, 32'h0004_0000, 32'h0002_0000);
        random_triangles(20, 0);
        tx_fast = 1'b1;
        hold_token++;
        random_triangles(30, 0);
        drain();

        // degenerate in x, then in y only
        set_box($urandom(), $urandom(), 32'h0, 32'h0001_0000);
        random_triangles(25, 0);
        drain();
        set_box($urandom(), $urandom(), Q_MAX, 32'h0);
        random_triangles(20, 0);
        drain();

        // extreme boxes
        set_box(Q_MIN, Q_MIN, Q_MAX, Q_MAX);
        random_triangles(30, 0);
        drain();
        set_box(Q_MAX, 32'hFFFF_FFFF, 32'h1, 32'h1);
        random_triangles(25, 0);
        drain();

        // unit box again
        set_box('0, '0, 32'h0001_0000, 32'h0001_0000);
        random_triangles(25, 0);
        drain();

        if (errors == 0)
            $display("triangle_mesh_index_builder_top_tb OK");
        else
            $display("triangle_mesh_index_builder_top_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/tmib_pkg.sv
hw/rtl/tmib_front.sv
hw/rtl/tmib_fifo.sv
hw/rtl/tmib_back.sv
hw/rtl/triangle_mesh_index_builder_top.sv
tb/triangle_mesh_index_builder_top_tb.sv
